// ===== rtl/spdf_pkg.sv =====
// Shared types and constants of the subnet payload drop filter.
`timescale 1ns / 1ps

package spdf_pkg;

  localparam int unsigned CountW  = 32;
  localparam int unsigned PrefixW = 24;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CountW-1:0]  CountMax     = '1;
  localparam logic [PrefixW-1:0] ResetPrefix  = 24'h32A8C0;
  localparam logic [ByteW-1:0]   ResetProto   = 8'd6;
  localparam logic [ByteW-1:0]   ResetByte    = 8'd88;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BLOCK_PREFIX   = 2'd0,
    REG_MATCH_PROTOCOL = 2'd1,
    REG_MATCH_BYTE     = 2'd2
  } cfg_reg_e;

  // one row of statistics per protocol
  typedef struct packed {
    logic [CountW-1:0] peak_delta;
    logic [CountW-1:0] last_count;
    logic [CountW-1:0] drops;
  } stat_entry_t;

endpackage

// ===== rtl/spdf_stat_ram.sv =====
// Per-protocol statistics memory with valid bits and write-to-read forwarding.
`timescale 1ns / 1ps

module spdf_stat_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [AddrW-1:0]      rd_addr_i,
  output spdf_pkg::stat_entry_t rd_data_o,
  input  logic                  wr_en_i,
  input  logic [AddrW-1:0]      wr_addr_i,
  input  spdf_pkg::stat_entry_t wr_data_i
);
  import spdf_pkg::*;

  stat_entry_t             mem_q [Depth];
  logic        [Depth-1:0] vld_q;
  stat_entry_t             rd_raw_q;
  logic                    rd_vld_q;
  logic                    fwd_q;
  stat_entry_t             fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_raw_q   <= mem_q[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
        // same-edge write to the entry being read: take the new value
        fwd_q    <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  // an entry never written since reset reads as zero
  assign rd_data_o = fwd_q    ? fwd_data_q :
                     rd_vld_q ? rd_raw_q   : '0;

endmodule

// ===== rtl/subnet_payload_drop_filter_with_stats.sv =====
// Top level: packet drop filter with per-protocol drop counters and rate stats.
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Word
// -------   ---------  ---------------------   -----------------------------------------
// in        input      in_valid_i / in_stall_o  req_type, protocol, dest_addr, payload byte
// out       output     out_valid_o / out_stall_i drop, total_drops, rate_delta, max_rate
// cfg       input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// The statistics row of a word is read at the accept edge, then updated and written back
// when the update stage moves on, while the result loads the output register.
// A new word is accepted every cycle while in_stall_o is low; a read that hits the row
// written at the same edge is served by forwarding in the statistics memory.
// Reset clears the config registers to their defaults and the row valid bits, so every
// row reads as zero at once; no clearing pass is needed.
// A stalled output holds the result register; the update stage then holds and input stalls.

module subnet_payload_drop_filter_with_stats #(
  parameter int unsigned NUM_PROTOCOLS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [spdf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [spdf_pkg::PrefixW-1:0]  cfg_data_i,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [7:0]                    protocol_i,
  input  logic [31:0]                   dest_addr_i,
  input  logic [7:0]                    payload_byte_i,
  input  logic                          has_second_byte_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          drop_o,
  output logic [31:0]                   total_drops_o,
  output logic [31:0]                   rate_delta_o,
  output logic [31:0]                   max_rate_o
);
  import spdf_pkg::*;

  localparam int unsigned AddrW    = (NUM_PROTOCOLS > 1) ? $clog2(NUM_PROTOCOLS) : 1;
  localparam logic [8:0]  NumProtoW = 9'(NUM_PROTOCOLS);

  // configuration registers
  logic [PrefixW-1:0] block_prefix_q;
  logic [ByteW-1:0]   match_proto_q;
  logic [ByteW-1:0]   match_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_prefix_q <= ResetPrefix;
      match_proto_q  <= ResetProto;
      match_byte_q   <= ResetByte;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BLOCK_PREFIX:   block_prefix_q <= cfg_data_i;
        REG_MATCH_PROTOCOL: match_proto_q  <= cfg_data_i[ByteW-1:0];
        REG_MATCH_BYTE:     match_byte_q   <= cfg_data_i[ByteW-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Accept: classify the packet and issue the row read
  // ---------------------------------------------------------------------------
  logic in_acc;
  logic s1_go;
  logic in_range;
  logic hit;

  logic             s1_valid_q;
  logic             s1_type_q;
  logic             s1_hit_q;
  logic             s1_range_q;
  logic [AddrW-1:0] s1_addr_q;

  logic        out_valid_q;
  logic        drop_q;
  logic [31:0] total_q;
  logic [31:0] delta_q;
  logic [31:0] maxr_q;

  // the update stage moves on when the result register is free or being emptied
  assign s1_go      = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign in_range = {1'b0, protocol_i} < NumProtoW;
  assign hit      = (protocol_i == match_proto_q)
                 && (dest_addr_i[PrefixW-1:0] == block_prefix_q)
                 && has_second_byte_i
                 && (payload_byte_i == match_byte_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_type_q  <= req_type_i;
      s1_hit_q   <= !req_type_i && hit;
      s1_range_q <= in_range;
      s1_addr_q  <= protocol_i[AddrW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Statistics memory
  // ---------------------------------------------------------------------------
  stat_entry_t rd_ent;
  stat_entry_t wr_ent;
  logic        wr_en;

  spdf_stat_ram #(
    .Depth (NUM_PROTOCOLS),
    .AddrW (AddrW)
  ) u_stat_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc && in_range),
    .rd_addr_i (protocol_i[AddrW-1:0]),
    .rd_data_o (rd_ent),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_ent)
  );

  // ---------------------------------------------------------------------------
  // Update: modify the row, write it back, load the result
  // ---------------------------------------------------------------------------
  logic [31:0] cnt_inc;
  logic [32:0] diff;
  logic [31:0] delta;
  logic        smp_upd;
  logic [31:0] res_total;
  logic [31:0] res_delta;
  logic [31:0] res_max;

  // saturate the counter; the packet is still dropped when it is full
  assign cnt_inc = (s1_hit_q && (rd_ent.drops != CountMax)) ?
                   rd_ent.drops + 32'd1 : rd_ent.drops;

  // absolute difference between counter and last sampled value
  assign diff  = {1'b0, rd_ent.drops} - {1'b0, rd_ent.last_count};
  assign delta = diff[32] ? (rd_ent.last_count - rd_ent.drops) : diff[31:0];

  // a sample of a zero counter leaves the row as it is
  assign smp_upd = rd_ent.drops != '0;

  always_comb begin
    wr_ent    = rd_ent;
    res_total = '0;
    res_delta = '0;
    res_max   = '0;
    if (!s1_type_q) begin
      wr_ent.drops = cnt_inc;
      res_total    = cnt_inc;
      res_max      = rd_ent.peak_delta;
    end else begin
      if (smp_upd) begin
        wr_ent.last_count = rd_ent.drops;
        res_delta         = delta;
        if (delta > rd_ent.peak_delta) begin
          wr_ent.peak_delta = delta;
        end
      end
      res_total = rd_ent.drops;
      res_max   = wr_ent.peak_delta;
    end
    // protocols past the table touch no row and report zero statistics
    if (!s1_range_q) begin
      res_total = '0;
      res_delta = '0;
      res_max   = '0;
    end
  end

  assign wr_en = s1_valid_q && s1_go && s1_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_go) begin
      drop_q  <= s1_hit_q;
      total_q <= res_total;
      delta_q <= res_delta;
      maxr_q  <= res_max;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drop_o        = drop_q;
  assign total_drops_o = total_q;
  assign rate_delta_o  = delta_q;
  assign max_rate_o    = maxr_q;

endmodule

// ===== sim/tb_subnet_payload_drop_filter_with_stats.sv =====
// Testbench of the subnet payload drop filter: directed table, random words, scoreboard.
`timescale 1ns / 1ps

module tb_subnet_payload_drop_filter_with_stats;
  import spdf_pkg::*;

  localparam int unsigned NumProto    = 256;
  localparam int unsigned DrainCycles = 4;      // margin after the pipe has emptied
  localparam int unsigned HoldCycles  = 300;    // long output hold-off
  localparam int unsigned PhaseWords  = 317;    // three phases, about 950 words
  localparam int unsigned CycleLimit  = 200000;

  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;  // no register behind this index
  localparam logic ReqPacket = 1'b0;
  localparam logic ReqSample = 1'b1;

  typedef struct packed {
    logic        req;
    logic [7:0]  proto;
    logic [31:0] dest;
    logic [7:0]  pbyte;
    logic        has2;
  } word_t;

  typedef struct packed {
    logic        drop;
    logic [31:0] total;
    logic [31:0] delta;
    logic [31:0] peak;
  } result_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  // One row of the directed table: a register write or a word, the latter
  // with an optional hand-written result.
  typedef struct packed {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [PrefixW-1:0]   data;
    word_t                w;
    logic                 typed;
    result_t              want;
  } row_t;

  // DUT-facing signals; the driven ones are known from time zero
  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx    = '0;
  logic [PrefixW-1:0]  cfg_data   = '0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic                req_type   = 1'b0;
  logic [7:0]          protocol   = '0;
  logic [31:0]         dest_addr  = '0;
  logic [7:0]          pay_byte   = '0;
  logic                has_second = 1'b0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic                drop;
  logic [31:0]         total_drops;
  logic [31:0]         rate_delta;
  logic [31:0]         max_rate;

  // filter settings and statistics as the block should hold them
  logic [PrefixW-1:0]  prefix_m = ResetPrefix;
  logic [7:0]          proto_m  = ResetProto;
  logic [7:0]          byte_m   = ResetByte;
  logic [31:0]         drops_m [NumProto] = '{default: '0};
  logic [31:0]         sampled_m [NumProto] = '{default: '0};
  logic [31:0]         peak_m [NumProto] = '{default: '0};

  result_t             pending_q [$];   // results owed by the block, oldest first
  int unsigned         errors   = 0;
  int unsigned         cycles   = 0;
  int unsigned         send_idle_pct = 36;
  int unsigned         recv_idle_pct = 59;
  logic                hold_go  = 1'b0;
  logic                hold_on  = 1'b0;

  subnet_payload_drop_filter_with_stats #(
    .NUM_PROTOCOLS(NumProto)
  ) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .req_type_i       (req_type),
    .protocol_i       (protocol),
    .dest_addr_i      (dest_addr),
    .payload_byte_i   (pay_byte),
    .has_second_byte_i(has_second),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .drop_o           (drop),
    .total_drops_o    (total_drops),
    .rate_delta_o     (rate_delta),
    .max_rate_o       (max_rate)
  );

  always #1 clk = ~clk;

  // Classify or sample one word and advance the statistics copy.
  function automatic result_t filter_word(input word_t w);
    result_t     r;
    logic        hit;
    logic        in_range;
    logic [31:0] cur;
    logic [31:0] prev;
    r = '0;
    in_range = int'(w.proto) < NumProto;
    if (w.req == ReqPacket) begin
      hit = (w.proto == proto_m) && (w.dest[23:0] == prefix_m) && w.has2 &&
            (w.pbyte == byte_m);
      r.drop = hit;
      // a full counter holds, the packet is dropped all the same
      if (hit && in_range && drops_m[w.proto] != CountMax)
        drops_m[w.proto] = drops_m[w.proto] + 32'd1;
      if (in_range) begin
        r.total = drops_m[w.proto];
        r.peak  = peak_m[w.proto];
      end
    end else if (in_range) begin
      cur = drops_m[w.proto];
      // a zero counter leaves every store as it is
      if (cur != 32'd0) begin
        prev = sampled_m[w.proto];
        r.delta = (cur >= prev) ? cur - prev : prev - cur;
        sampled_m[w.proto] = cur;
        if (r.delta > peak_m[w.proto])
          peak_m[w.proto] = r.delta;
      end
      r.total = cur;
      r.peak  = peak_m[w.proto];
    end
    return r;
  endfunction

  function automatic void apply_setting(input logic [CfgIdxW-1:0] idx,
                                        input logic [PrefixW-1:0] data);
    case (idx)
      REG_BLOCK_PREFIX:   prefix_m = data;
      REG_MATCH_PROTOCOL: proto_m  = data[7:0];
      REG_MATCH_BYTE:     byte_m   = data[7:0];
      default: ;
    endcase
  endfunction

  // Random word: packets that hit the filter (the largest share), near misses,
  // samples and plain noise.
  function automatic word_t random_word();
    word_t       w;
    int          sel;
    int unsigned bit_sel;
    sel     = $urandom_range(99);
    w.req   = ReqPacket;
    w.proto = proto_m;
    w.dest  = {8'($urandom()), prefix_m};
    w.pbyte = byte_m;
    w.has2  = 1'b1;
    if (sel < 45) begin
      // hit as built
    end else if (sel < 57) begin
      case ($urandom_range(3))
        0: w.proto = w.proto ^ 8'($urandom_range(1, 255));
        1: begin
          bit_sel = $urandom_range(23);
          w.dest[bit_sel] = ~w.dest[bit_sel];
        end
        2: w.has2 = 1'b0;
        default: w.pbyte = w.pbyte ^ 8'($urandom_range(1, 255));
      endcase
    end else if (sel < 82) begin
      w.req   = ReqSample;
      w.dest  = $urandom();
      w.pbyte = 8'($urandom());
      w.has2  = 1'($urandom());
      if (sel >= 75)
        w.proto = 8'($urandom());
    end else begin
      w.req   = 1'($urandom());
      w.proto = 8'($urandom());
      w.dest  = $urandom();
      w.pbyte = 8'($urandom());
      w.has2  = 1'($urandom());
    end
    return w;
  endfunction

  function automatic row_t word_row(input logic req, input logic [7:0] proto,
                                    input logic [31:0] dest, input logic [7:0] pbyte,
                                    input logic has2);
    row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.w    = '{req: req, proto: proto, dest: dest, pbyte: pbyte, has2: has2};
    return r;
  endfunction

  function automatic row_t known_row(input logic req, input logic [7:0] proto,
                                     input logic [31:0] dest, input logic [7:0] pbyte,
                                     input logic has2, input int drop_v,
                                     input logic [31:0] total_v, input logic [31:0] delta_v,
                                     input logic [31:0] peak_v);
    row_t r;
    r       = word_row(req, proto, dest, pbyte, has2);
    r.typed = 1'b1;
    r.want  = '{drop: 1'(drop_v), total: total_v, delta: delta_v, peak: peak_v};
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [CfgIdxW-1:0] idx,
                                   input logic [PrefixW-1:0] data);
    row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  // Offer one word, hold it until accepted, then log the result it owes.
  // Returns in the time step of the accepting edge.
  task automatic send_word(input word_t w, input logic typed, input result_t want);
    result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= w.req;
    protocol   <= w.proto;
    dest_addr  <= w.dest;
    pay_byte   <= w.pbyte;
    has_second <= w.has2;
    do @(posedge clk); while (in_stall);
    pred = filter_word(w);
    pending_q.push_back(typed ? want : pred);
  endtask

  // Drop valid and wait until the block has nothing left in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PrefixW-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    apply_setting(idx, data);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Receiver: stall at random, or for the whole hold-off, and score every
  // accepted result against the oldest one owed.
  always @(posedge clk) begin : rx_side
    result_t got;
    result_t want;
    out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      got = '{drop: drop, total: total_drops, delta: rate_delta, peak: max_rate};
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: drop %0b total %0d delta %0d max %0d",
                   got.drop, got.total, got.delta, got.peak);
      end else begin
        want = pending_q.pop_front();
        if (got.drop !== want.drop || got.total !== want.total ||
            got.delta !== want.delta || got.peak !== want.peak) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: drop %0b/%0b total %0d/%0d delta %0d/%0d max %0d/%0d",
                     want.drop, got.drop, want.total, got.total,
                     want.delta, got.delta, want.peak, got.peak);
        end
      end
    end
  end

  // Long output hold-off, counted here while the sender keeps offering words.
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : main
    row_t rows [$];
    // Settings after reset: 192.168.50.0/24, TCP, 'X'.
    rows.push_back(known_row(ReqSample, 8'd6, 32'h0, 8'h0, 1'b0, 0, 0, 0, 0));
    rows.push_back(known_row(ReqPacket, 8'd6, 32'h0132A8C0, 8'd88, 1'b1, 1, 1, 0, 0));
    // no second byte: never a hit
    rows.push_back(known_row(ReqPacket, 8'd6, 32'h0132A8C0, 8'd88, 1'b0, 0, 1, 0, 0));
    rows.push_back(known_row(ReqPacket, 8'd6, 32'h0132A8C0, 8'd87, 1'b1, 0, 1, 0, 0));
    rows.push_back(known_row(ReqPacket, 8'd17, 32'h0132A8C0, 8'd88, 1'b1, 0, 0, 0, 0));
    rows.push_back(known_row(ReqPacket, 8'd6, 32'h0132A8C1, 8'd88, 1'b1, 0, 1, 0, 0));
    rows.push_back(known_row(ReqPacket, 8'd6, 32'hFF32A8C0, 8'd88, 1'b1, 1, 2, 0, 0));
    rows.push_back(known_row(ReqSample, 8'd6, 32'h0, 8'h0, 1'b0, 0, 2, 2, 2));
    // sample ignores address and byte fields
    rows.push_back(known_row(ReqSample, 8'd6, 32'hFFFFFFFF, 8'hFF, 1'b1, 0, 2, 0, 2));
    rows.push_back(known_row(ReqPacket, 8'd6, 32'h0132A8C0, 8'd88, 1'b1, 1, 3, 0, 2));
    rows.push_back(known_row(ReqSample, 8'd6, 32'h0, 8'h0, 1'b0, 0, 3, 1, 2));
    // sample of a zero counter
    rows.push_back(known_row(ReqSample, 8'd255, 32'h0, 8'h0, 1'b0, 0, 0, 0, 0));
    rows.push_back(known_row(ReqPacket, 8'd0, 32'h0, 8'h0, 1'b0, 0, 0, 0, 0));
    rows.push_back(known_row(ReqPacket, 8'd255, 32'hFFFFFFFF, 8'hFF, 1'b1, 0, 0, 0, 0));
    // upper extremes; the unused index must not disturb the prefix
    rows.push_back(cfg_row(REG_BLOCK_PREFIX, 24'hFFFFFF));
    rows.push_back(cfg_row(RegUnused, 24'h123456));
    rows.push_back(cfg_row(REG_MATCH_PROTOCOL, 24'hFFFFFF));
    rows.push_back(cfg_row(REG_MATCH_BYTE, 24'h0000FF));
    rows.push_back(known_row(ReqPacket, 8'd255, 32'hFFFFFFFF, 8'hFF, 1'b1, 1, 1, 0, 0));
    rows.push_back(known_row(ReqPacket, 8'd255, 32'hFFFFFFFF, 8'hFF, 1'b0, 0, 1, 0, 0));
    rows.push_back(known_row(ReqSample, 8'd255, 32'h0, 8'h0, 1'b0, 0, 1, 1, 1));
    rows.push_back(word_row(ReqPacket, 8'd6, 32'h0132A8C0, 8'd88, 1'b1));
    // lower extremes; high data bits of the byte registers are dropped
    rows.push_back(cfg_row(REG_BLOCK_PREFIX, 24'h000000));
    rows.push_back(cfg_row(REG_MATCH_PROTOCOL, 24'hABCD00));
    rows.push_back(cfg_row(REG_MATCH_BYTE, 24'hFFFF00));
    rows.push_back(known_row(ReqPacket, 8'd0, 32'h0, 8'h0, 1'b1, 1, 1, 0, 0));
    rows.push_back(word_row(ReqPacket, 8'd0, 32'hFF000000, 8'h0, 1'b1));
    rows.push_back(word_row(ReqPacket, 8'd0, 32'h00000001, 8'h0, 1'b1));
    rows.push_back(word_row(ReqSample, 8'd0, 32'h0, 8'h0, 1'b0));
    rows.push_back(word_row(ReqSample, 8'd6, 32'h0, 8'h0, 1'b0));
    rows.push_back(word_row(ReqPacket, 8'd0, 32'h0, 8'h1, 1'b1));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table under the first idling mix
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_word(rows[i].w, rows[i].typed, rows[i].want);
      end
    end

    // random phases: receiver-heavy idling, sender-heavy idling, then none
    for (int p = 0; p < 3; p++) begin
      drain();
      send_idle_pct <= (p == 0) ? 36 : (p == 1) ? 59 : 0;
      recv_idle_pct <= (p == 0) ? 59 : (p == 1) ? 36 : 0;
      write_reg(REG_BLOCK_PREFIX, 24'($urandom()));
      write_reg(REG_MATCH_PROTOCOL, 24'($urandom()));
      write_reg(REG_MATCH_BYTE, 24'($urandom()));
      write_reg(RegUnused, 24'($urandom()));
      // fill the pipe against a held output and stall the input
      if (p == 2)
        hold_go = 1'b1;
      for (int n = 0; n < PhaseWords; n++)
        send_word(random_word(), 1'b0, '0);
    end

    drain();
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/spdf_pkg.sv
rtl/spdf_stat_ram.sv
rtl/subnet_payload_drop_filter_with_stats.sv
sim/tb_subnet_payload_drop_filter_with_stats.sv
